@@ rtl/home_computer_bus_and_text_video_assert.svh @@
// Assertion macros shared by the bus and text video block.
`ifndef HOME_COMPUTER_BUS_AND_TEXT_VIDEO_ASSERT_SVH
`define HOME_COMPUTER_BUS_AND_TEXT_VIDEO_ASSERT_SVH
`ifndef SYNTHESIS
`define HCTV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hctv: same-cycle check failed");
`define HCTV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hctv: next-cycle check failed");
`else
`define HCTV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HCTV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/hctv_pkg.sv @@
// Shared types, codes, microcode program and colour fold of the bus and text video block.
package hctv_pkg;

    localparam int unsigned MONITOR_ROM_BYTES = 8192;
    localparam int unsigned MON_AW            = 13;
    localparam int unsigned FONT_CHARACTERS   = 256;
    localparam int unsigned FONT_AW           = 11;

    localparam logic [15:0] ROM_TOP     = 16'h2000;
    localparam logic [15:0] RAM_BASE    = 16'h3000;
    localparam logic [15:0] SCREEN_END  = 16'h3800;
    localparam logic [9:0]  CELL_FIRST  = 10'd40;
    localparam logic [9:0]  CELL_END    = 10'd1000;
    localparam logic [10:0] COLOUR_OFFSET = 11'h400;
    localparam logic [10:0] RECIP_40    = 11'd1639;   // ceil(65536 / 40), exact below 1024
    localparam logic [13:0] LINE_STRIDE = 14'd40;     // 320 / 8 bytes per pixel line
    localparam logic [13:0] ROW_STEP    = 14'd280;    // 320 per text row less 40 per cell index
    localparam logic [13:0] ROW_BIAS    = 14'd320;    // the hidden top row
    localparam logic [7:0]  KEY_PORT    = 8'hFF;

    // Bus functions
    localparam logic [2:0] FUNC_MEM_READ  = 3'd0;
    localparam logic [2:0] FUNC_MEM_WRITE = 3'd1;
    localparam logic [2:0] FUNC_PORT_READ = 3'd2;
    localparam logic [2:0] FUNC_ROM_LOAD  = 3'd3;
    localparam logic [2:0] FUNC_FONT_LOAD = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // Sequencer steps
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RD_FETCH  = 4'd1;
    localparam logic [3:0] ST_RD_EMIT   = 4'd2;
    localparam logic [3:0] ST_WR_FETCH  = 4'd3;
    localparam logic [3:0] ST_WR_STORE  = 4'd4;
    localparam logic [3:0] ST_CODE      = 4'd5;
    localparam logic [3:0] ST_COLOUR    = 4'd6;
    localparam logic [3:0] ST_FONT      = 4'd7;
    localparam logic [3:0] ST_LINE      = 4'd8;
    localparam logic [3:0] ST_KEYS      = 4'd9;
    localparam logic [3:0] ST_LOAD_ROM  = 4'd10;
    localparam logic [3:0] ST_LOAD_FONT = 4'd11;
    localparam logic [3:0] ST_CLEAR     = 4'd12;

    // Datapath actions
    localparam logic [3:0] ACT_NOP          = 4'd0;
    localparam logic [3:0] ACT_FETCH        = 4'd1;
    localparam logic [3:0] ACT_EMIT_READ    = 4'd2;
    localparam logic [3:0] ACT_WRITE        = 4'd3;
    localparam logic [3:0] ACT_FETCH_CODE   = 4'd4;
    localparam logic [3:0] ACT_FETCH_COLOUR = 4'd5;
    localparam logic [3:0] ACT_FONT_FIRST   = 4'd6;
    localparam logic [3:0] ACT_EMIT_LINE    = 4'd7;
    localparam logic [3:0] ACT_EMIT_KEYS    = 4'd8;
    localparam logic [3:0] ACT_LOAD_ROM     = 4'd9;
    localparam logic [3:0] ACT_LOAD_FONT    = 4'd10;
    localparam logic [3:0] ACT_CLEAR        = 4'd11;

    // Jump conditions
    localparam logic [2:0] COND_NEVER      = 3'd0;
    localparam logic [2:0] COND_ALWAYS     = 3'd1;
    localparam logic [2:0] COND_NOT_RAM    = 3'd2;
    localparam logic [2:0] COND_NO_PAINT   = 3'd3;
    localparam logic [2:0] COND_MORE_LINES = 3'd4;
    localparam logic [2:0] COND_CLEAR_LEFT = 3'd5;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] cond;
        logic [3:0] target;
        logic       done;
    } t_uword;

    typedef struct packed {
        logic       capture;
        logic [3:0] act;
    } t_dp_ctrl;

    typedef struct packed {
        logic out_free;
        logic not_ram;
        logic no_paint;
        logic more_lines;
        logic clear_left;
    } t_dp_status;

    // Control store: a jump is taken when its condition holds, otherwise the
    // step either falls through or, with done set, returns to idle.
    function automatic t_uword microcode(input logic [3:0] step);
        t_uword w;
        unique case (step)
            ST_RD_FETCH:  w = '{ACT_FETCH,        COND_NEVER,      ST_IDLE,  1'b0};
            ST_RD_EMIT:   w = '{ACT_EMIT_READ,    COND_NEVER,      ST_IDLE,  1'b1};
            ST_WR_FETCH:  w = '{ACT_FETCH,        COND_NOT_RAM,    ST_IDLE,  1'b0};
            ST_WR_STORE:  w = '{ACT_WRITE,        COND_NO_PAINT,   ST_IDLE,  1'b0};
            ST_CODE:      w = '{ACT_FETCH_CODE,   COND_NEVER,      ST_IDLE,  1'b0};
            ST_COLOUR:    w = '{ACT_FETCH_COLOUR, COND_NEVER,      ST_IDLE,  1'b0};
            ST_FONT:      w = '{ACT_FONT_FIRST,   COND_NEVER,      ST_IDLE,  1'b0};
            ST_LINE:      w = '{ACT_EMIT_LINE,    COND_MORE_LINES, ST_LINE,  1'b1};
            ST_KEYS:      w = '{ACT_EMIT_KEYS,    COND_NEVER,      ST_IDLE,  1'b1};
            ST_LOAD_ROM:  w = '{ACT_LOAD_ROM,     COND_NEVER,      ST_IDLE,  1'b1};
            ST_LOAD_FONT: w = '{ACT_LOAD_FONT,    COND_NEVER,      ST_IDLE,  1'b1};
            ST_CLEAR:     w = '{ACT_CLEAR,        COND_CLEAR_LEFT, ST_CLEAR, 1'b1};
            default:      w = '{ACT_NOP,          COND_ALWAYS,     ST_IDLE,  1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] entry_step(input logic [2:0] func);
        logic [3:0] s;
        unique case (func)
            FUNC_MEM_READ:  s = ST_RD_FETCH;
            FUNC_MEM_WRITE: s = ST_WR_FETCH;
            FUNC_PORT_READ: s = ST_KEYS;
            FUNC_ROM_LOAD:  s = ST_LOAD_ROM;
            FUNC_FONT_LOAD: s = ST_LOAD_FONT;
            default:        s = ST_IDLE;
        endcase
        return s;
    endfunction

    // Sixteen colours fold onto eight: the upper half mirrors the lower half.
    function automatic logic [2:0] colour_fold(input logic [3:0] n);
        return n[3] ? ~n[2:0] : n[2:0];
    endfunction

endpackage

@@ rtl/home_computer_bus_and_text_video.sv @@
// Top level of the bus decode and write-through text video block.
// Each request carries a bus function, an address, a data byte and the key matrix. A memory
// read returns one byte: monitor ROM below 0x2000, RAM from 0x3000 up to 0x4000 plus
// EXTENDED_RAM_BYTES, and 0xFF elsewhere. A port read at a low address byte of 0xFF returns
// the active-low key scan of every row whose address high bit is clear; other ports read 0.
// A write into RAM that changes a byte of a visible cell in the character or colour area
// repaints the text cell as eight bitmap lines, each with three bitplane bytes and its
// offset in the 320x240 planes; the last line is flagged. ROM and font loads, unused
// function codes and writes outside RAM give no results. A microcoded sequencer drives
// every RAM access: a read fetches and then emits its byte, a write into RAM fetches the
// old byte and stores the new one, and a repainting write then fetches the code, the
// colour and the first font line and emits the eight line results one per cycle while
// the output is not stalled. After reset all EXTENDED_RAM_BYTES + 4096 bytes of RAM
// (20480 by default) are cleared one byte per cycle, during which no request is taken.
// The result register lets a new request be accepted while the last result still waits.
module home_computer_bus_and_text_video #(
    parameter int unsigned EXTENDED_RAM_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [47:0] i_key_matrix,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_plane_bit0,
    output logic [7:0]  o_plane_bit1,
    output logic [7:0]  o_plane_bit2,
    output logic [13:0] o_line_offset,
    output logic        o_last
);
    import hctv_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status status;

    // The sequencer steps through the control store and issues one action per cycle.
    hctv_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_stall  (o_stall),
        .o_ctrl   (ctrl)
    );

    // The datapath holds the stores, the painter and the result register.
    hctv_dpath #(
        .EXTENDED_RAM_BYTES (EXTENDED_RAM_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_key_matrix  (i_key_matrix),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_read_data   (o_read_data),
        .o_plane_bit0  (o_plane_bit0),
        .o_plane_bit1  (o_plane_bit1),
        .o_plane_bit2  (o_plane_bit2),
        .o_line_offset (o_line_offset),
        .o_last        (o_last)
    );

endmodule

@@ rtl/hctv_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`include "home_computer_bus_and_text_video_assert.svh"
module hctv_useq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [2:0]             i_func,
    input  hctv_pkg::t_dp_status   i_status,
    output logic                   o_stall,
    output hctv_pkg::t_dp_ctrl     o_ctrl
);
    import hctv_pkg::*;

    logic [3:0] r_step;
    logic [3:0] n_step;
    t_uword     uw;
    logic       accept;
    logic       is_emit;
    logic       hold;
    logic       cond_true;

    assign uw      = microcode(r_step);
    assign accept  = (r_step == ST_IDLE) && i_valid;
    assign o_stall = (r_step != ST_IDLE);
    assign is_emit = (uw.act inside {ACT_EMIT_READ, ACT_EMIT_LINE, ACT_EMIT_KEYS});
    assign hold    = is_emit && !i_status.out_free;

    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_NOT_RAM:    cond_true = i_status.not_ram;
            COND_NO_PAINT:   cond_true = i_status.no_paint;
            COND_MORE_LINES: cond_true = i_status.more_lines;
            COND_CLEAR_LEFT: cond_true = i_status.clear_left;
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (r_step == ST_IDLE) begin
            n_step = accept ? entry_step(i_func) : ST_IDLE;
        end else if (hold) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uw.target;
        end else if (uw.done) begin
            n_step = ST_IDLE;
        end else begin
            n_step = 4'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.capture = accept;
    assign o_ctrl.act     = uw.act;

    `HCTV_ASSERT_NXT(a_emit_holds_when_busy, i_clk, i_rst_n, hold, $stable(r_step))
    `HCTV_ASSERT_NXT(a_last_line_returns, i_clk, i_rst_n, (r_step == ST_LINE) && !hold && !i_status.more_lines, r_step == ST_IDLE)
    `HCTV_ASSERT_NXT(a_read_dispatch, i_clk, i_rst_n, accept && (i_func == FUNC_MEM_READ), r_step == ST_RD_FETCH)

endmodule

@@ rtl/hctv_dpath.sv @@
// Datapath: request registers, RAM and ROM stores, cell painter and result register.
module hctv_dpath #(
    parameter int unsigned EXTENDED_RAM_BYTES = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hctv_pkg::t_dp_ctrl   i_ctrl,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_data,
    input  logic [47:0]          i_key_matrix,
    output hctv_pkg::t_dp_status o_status,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [7:0]           o_read_data,
    output logic [7:0]           o_plane_bit0,
    output logic [7:0]           o_plane_bit1,
    output logic [7:0]           o_plane_bit2,
    output logic [13:0]          o_line_offset,
    output logic                 o_last
);
    import hctv_pkg::*;

    localparam int unsigned RAM_BYTES = EXTENDED_RAM_BYTES + 4096;
    localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
    localparam logic [16:0] RAM_LIMIT = 17'(32'h3000 + RAM_BYTES);
    localparam logic [RAM_AW-1:0] CLEAR_LAST = RAM_AW'(RAM_BYTES - 1);

    logic [7:0] ram  [RAM_BYTES];
    logic [7:0] mon  [MONITOR_ROM_BYTES];
    logic [7:0] font [FONT_CHARACTERS * 8];

    logic [15:0]       r_addr;
    logic [7:0]        r_data;
    logic [47:0]       r_keys;
    logic [7:0]        r_ram_q;
    logic [7:0]        r_mon_q;
    logic [7:0]        r_font_q;
    logic [RAM_AW-1:0] r_clr;
    logic [4:0]        r_q;
    logic [7:0]        r_code;
    logic [7:0]        r_colour;
    logic [2:0]        r_line;
    logic [13:0]       r_offset;
    logic              r_o_valid;

    logic              in_ram;
    logic [15:0]       ram_off;
    logic [RAM_AW-1:0] ram_idx;
    logic [9:0]        cell_idx;
    logic [RAM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              out_free;
    logic              font_rd;
    logic [2:0]        font_line;
    logic [20:0]       quot_prod;
    logic [5:0]        key_or;
    logic [7:0]        key_byte;
    logic [7:0]        mem_byte;
    logic [2:0]        fg;
    logic [2:0]        bg;
    logic              emit_read;
    logic              emit_keys;
    logic              emit_line;

    assign in_ram   = (r_addr >= RAM_BASE) && ({1'b0, r_addr} < RAM_LIMIT);
    assign ram_off  = r_addr - RAM_BASE;
    assign ram_idx  = ram_off[RAM_AW-1:0];
    assign cell_idx = r_addr[9:0];
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        unique case (i_ctrl.act)
            ACT_FETCH_CODE:   rd_addr = RAM_AW'(cell_idx);
            ACT_FETCH_COLOUR: rd_addr = RAM_AW'({1'b0, cell_idx} + COLOUR_OFFSET);
            default:          rd_addr = ram_idx;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ram_idx;
        wr_data = r_data;
        if (i_ctrl.act == ACT_WRITE) begin
            wr_en = 1'b1;
        end else if (i_ctrl.act == ACT_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        r_ram_q <= ram[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_LOAD_ROM) begin
            mon[r_addr[MON_AW-1:0]] <= r_data;
        end
        r_mon_q <= mon[r_addr[MON_AW-1:0]];
    end

    assign emit_read = (i_ctrl.act == ACT_EMIT_READ) && out_free;
    assign emit_keys = (i_ctrl.act == ACT_EMIT_KEYS) && out_free;
    assign emit_line = (i_ctrl.act == ACT_EMIT_LINE) && out_free;
    assign font_rd   = (i_ctrl.act == ACT_FONT_FIRST) || emit_line;
    assign font_line = (i_ctrl.act == ACT_FONT_FIRST) ? 3'd0 : 3'(r_line + 3'd1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_LOAD_FONT) begin
            font[r_addr[FONT_AW-1:0]] <= r_data;
        end
        if (font_rd) begin
            r_font_q <= font[{r_code, font_line}];
        end
    end

    // Text row of the cell: multiply by the reciprocal of 40.
    assign quot_prod = 21'(cell_idx) * 21'(RECIP_40);

    always_comb begin
        key_or = '0;
        for (int r = 0; r < 8; r++) begin
            if (!r_addr[8 + r]) begin
                key_or = key_or | r_keys[r*6 +: 6];
            end
        end
        key_byte = (r_addr[7:0] == KEY_PORT) ? ~{2'b00, key_or} : 8'h00;
    end

    assign mem_byte = (r_addr < ROM_TOP) ? r_mon_q : (in_ram ? r_ram_q : 8'hFF);
    assign fg = colour_fold(r_colour[7:4]);
    assign bg = colour_fold(r_colour[3:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_addr <= i_address;
            r_data <= i_data;
            r_keys <= i_key_matrix;
        end
        if (i_ctrl.act == ACT_WRITE) begin
            r_q <= quot_prod[20:16];
        end
        if (i_ctrl.act == ACT_FETCH_CODE) begin
            r_offset <= 14'({4'b0000, cell_idx}) + 14'(14'(r_q) * ROW_STEP) - ROW_BIAS;
        end else if (emit_line) begin
            r_offset <= r_offset + LINE_STRIDE;
        end
        if (i_ctrl.act == ACT_FETCH_COLOUR) begin
            r_code <= r_ram_q;
        end
        if (i_ctrl.act == ACT_FONT_FIRST) begin
            r_colour <= r_ram_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_line    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctrl.act == ACT_CLEAR) begin
                r_clr <= RAM_AW'(r_clr + 1'b1);
            end
            if (i_ctrl.act == ACT_FONT_FIRST) begin
                r_line <= '0;
            end else if (emit_line) begin
                r_line <= 3'(r_line + 3'd1);
            end
            if (emit_read || emit_keys || emit_line) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_read || emit_keys) begin
            o_kind        <= KIND_READ;
            o_read_data   <= emit_keys ? key_byte : mem_byte;
            o_plane_bit0  <= 8'h00;
            o_plane_bit1  <= 8'h00;
            o_plane_bit2  <= 8'h00;
            o_line_offset <= '0;
            o_last        <= 1'b1;
        end else if (emit_line) begin
            o_kind        <= KIND_LINE;
            o_read_data   <= 8'h00;
            o_plane_bit0  <= (r_font_q & {8{fg[0]}}) | (~r_font_q & {8{bg[0]}});
            o_plane_bit1  <= (r_font_q & {8{fg[1]}}) | (~r_font_q & {8{bg[1]}});
            o_plane_bit2  <= (r_font_q & {8{fg[2]}}) | (~r_font_q & {8{bg[2]}});
            o_line_offset <= r_offset;
            o_last        <= (r_line == 3'd7);
        end
    end

    assign o_valid = r_o_valid;

    assign o_status.out_free   = out_free;
    assign o_status.not_ram    = !in_ram;
    assign o_status.no_paint   = !((r_ram_q != r_data) && (r_addr < SCREEN_END)
                                   && (cell_idx >= CELL_FIRST) && (cell_idx < CELL_END));
    assign o_status.more_lines = (r_line != 3'd7);
    assign o_status.clear_left = (r_clr != CLEAR_LAST);

endmodule

@@ test/home_computer_bus_and_text_video_tb.sv @@
// Self-checking testbench for the bus decode and text video block, with its own bus and screen model.
module home_computer_bus_and_text_video_tb;
    import hctv_pkg::*;

    // Sizes of the block as built here. The RAM spans the screen areas and the extended RAM.
    localparam int unsigned EXT_RAM_BYTES = 16384;
    localparam int unsigned RAM_BYTES     = EXT_RAM_BYTES + 4096;
    localparam int unsigned FONT_BYTES    = FONT_CHARACTERS * 8;

    // Screen geometry: 40 columns by 24 visible rows, with a hidden row above them.
    localparam int unsigned TEXT_COLUMNS    = 40;
    localparam int unsigned TEXT_ROWS       = 24;
    localparam int unsigned CELL_LIMIT      = TEXT_COLUMNS * (TEXT_ROWS + 1);
    localparam int unsigned PIXEL_ROW_BYTES = 320 / 8;
    localparam int unsigned CELL_ROW_BYTES  = 320;
    localparam int unsigned COLOUR_AREA     = 'h400;

    // Number of character codes whose glyphs are loaded and written to the screen.
    localparam int unsigned SCREEN_CODES = 4;

    // Function codes that the block leaves without effect.
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    // No request is taken while the RAM is cleared after reset, so the watchdog limit
    // lies well above the length of that clear.
    localparam int unsigned IDLE_LIMIT    = 100000;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] address;
        logic [7:0]  data;
        logic [47:0] keys;
        logic        wait_drain;  // hold this request back until every result has arrived
        logic        calm;        // no idling on either side while this request is current
    } t_bus_request;

    typedef struct packed {
        logic        kind;
        logic [7:0]  read_data;
        logic [7:0]  plane0;
        logic [7:0]  plane1;
        logic [7:0]  plane2;
        logic [13:0] line_offset;
        logic        last;
    } t_bus_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [2:0]  i_func       = '0;
    logic [15:0] i_address    = '0;
    logic [7:0]  i_data       = '0;
    logic [47:0] i_key_matrix = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [7:0]  o_read_data;
    logic [7:0]  o_plane_bit0;
    logic [7:0]  o_plane_bit1;
    logic [7:0]  o_plane_bit2;
    logic [13:0] o_line_offset;
    logic        o_last;

    // Model of the block's storage, updated as each request is accepted.
    logic [7:0] shadow_ram  [0:RAM_BYTES-1];
    logic [7:0] shadow_rom  [0:MONITOR_ROM_BYTES-1];
    logic [7:0] shadow_font [0:FONT_BYTES-1];

    t_bus_request request_q[$];
    t_bus_result  expected_results[$];
    t_bus_request held_request;

    // Monitor ROM bytes that the stimulus has already loaded; reads of the ROM area
    // only ever touch these, since an unloaded byte has no defined value.
    bit          rom_known [0:MONITOR_ROM_BYTES-1];
    int unsigned rom_known_list[$];

    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count  = 0;
    logic        calm_now     = 1'b0;

    home_computer_bus_and_text_video #(
        .EXTENDED_RAM_BYTES(EXT_RAM_BYTES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_address(i_address),
        .i_data(i_data),
        .i_key_matrix(i_key_matrix),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_kind(o_kind),
        .o_read_data(o_read_data),
        .o_plane_bit0(o_plane_bit0),
        .o_plane_bit1(o_plane_bit1),
        .o_plane_bit2(o_plane_bit2),
        .o_line_offset(o_line_offset),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // Sixteen colours fold onto eight; the upper half runs back down from seven.
    function automatic logic [2:0] fold_nibble(input logic [3:0] n);
        return (n < 4'd8) ? n[2:0] : 3'(4'd15 - n);
    endfunction

    // One bitplane byte of a glyph line: solid where both colours carry the bit, empty
    // where neither does, and the glyph or its inverse where only one of them does.
    function automatic logic [7:0] plane_value(input logic fg, input logic bg,
                                               input logic [7:0] glyph);
        if (fg && bg)
            return 8'hFF;
        if (!fg && !bg)
            return 8'h00;
        return fg ? glyph : ~glyph;
    endfunction

    // The character codes that the stimulus puts on screen. Code zero is among them,
    // since the cleared RAM shows it in every cell that is never written.
    function automatic logic [7:0] screen_code(input int unsigned k);
        case (k)
            0:       return 8'h00;
            1:       return 8'h41;
            2:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // Most gaps and stalls are short, a few are long, and calm stretches have none.
    function automatic int unsigned idle_length(input logic calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] random_keys();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic push_read_result(input logic [7:0] value);
        t_bus_result r;
        r = '0;
        r.kind = KIND_READ;
        r.read_data = value;
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    // Works out the results of one accepted request and applies its effect on storage.
    task automatic predict_bus_request(input t_bus_request req);
        int unsigned a, idx, cell_no, x, y, code, base;
        logic        changed;
        logic [7:0]  colour, glyph, scan;
        logic [2:0]  fg, bg;
        t_bus_result r;
        a = req.address;
        case (req.func)
            FUNC_MEM_READ: begin
                if (a < ROM_TOP)
                    push_read_result(shadow_rom[a]);
                else if (a >= RAM_BASE && a < RAM_BASE + RAM_BYTES)
                    push_read_result(shadow_ram[a - RAM_BASE]);
                else
                    push_read_result(8'hFF);
            end
            FUNC_MEM_WRITE: begin
                if (a >= RAM_BASE && a < RAM_BASE + RAM_BYTES) begin
                    idx = a - RAM_BASE;
                    changed = shadow_ram[idx] != req.data;
                    shadow_ram[idx] = req.data;
                    cell_no = a % 1024;
                    // Only a change inside the character or colour area of a visible
                    // cell repaints it; the hidden top row and the cells past the
                    // last row stay silent.
                    if (changed && a < SCREEN_END &&
                        cell_no >= TEXT_COLUMNS && cell_no < CELL_LIMIT) begin
                        x = cell_no % TEXT_COLUMNS;
                        y = cell_no / TEXT_COLUMNS - 1;
                        code = shadow_ram[cell_no];
                        colour = shadow_ram[cell_no + COLOUR_AREA];
                        fg = fold_nibble(colour[7:4]);
                        bg = fold_nibble(colour[3:0]);
                        base = x + y * CELL_ROW_BYTES;
                        for (int i = 0; i < 8; i++) begin
                            glyph = shadow_font[(code * 8 + i) % FONT_BYTES];
                            r = '0;
                            r.kind = KIND_LINE;
                            r.plane0 = plane_value(fg[0], bg[0], glyph);
                            r.plane1 = plane_value(fg[1], bg[1], glyph);
                            r.plane2 = plane_value(fg[2], bg[2], glyph);
                            r.line_offset = 14'(base + i * PIXEL_ROW_BYTES);
                            r.last = (i == 7);
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            FUNC_PORT_READ: begin
                // The key port scans every row whose address high bit is clear.
                if (req.address[7:0] == KEY_PORT) begin
                    scan = '0;
                    for (int row = 0; row < 8; row++)
                        if (!req.address[8 + row])
                            scan = scan | {2'b00, req.keys[row * 6 +: 6]};
                    push_read_result(~scan);
                end else begin
                    push_read_result(8'h00);
                end
            end
            FUNC_ROM_LOAD:
                shadow_rom[a % MONITOR_ROM_BYTES] = req.data;
            FUNC_FONT_LOAD:
                shadow_font[a % FONT_BYTES] = req.data;
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [2:0] func, input logic [15:0] address,
                                 input logic [7:0] data, input logic [47:0] keys,
                                 input logic wait_drain, input logic calm);
        t_bus_request req;
        req.func = func;
        req.address = address;
        req.data = data;
        req.keys = keys;
        req.wait_drain = wait_drain;
        req.calm = calm;
        request_q.push_back(req);
    endtask

    // Loads one monitor ROM byte through an index with random high bits, so that the
    // wrap to the ROM size is exercised as well.
    task automatic queue_monitor_load(input int unsigned idx, input logic calm);
        queue_request(FUNC_ROM_LOAD, 16'(idx + MONITOR_ROM_BYTES * $urandom_range(0, 7)),
                      8'($urandom), random_keys(), 1'b0, calm);
        if (!rom_known[idx]) begin
            rom_known[idx] = 1'b1;
            rom_known_list.push_back(idx);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Request driver. A request is taken at an edge where valid is high and the block
    // does not stall; the model is updated there. Payload holds steady while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall)
                predict_bus_request(held_request);
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    i_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].wait_drain && expected_results.size() != 0)) begin
                    held_request = request_q.pop_front();
                    i_func <= held_request.func;
                    i_address <= held_request.address;
                    i_data <= held_request.data;
                    i_key_matrix <= held_request.keys;
                    i_valid <= 1'b1;
                    calm_now <= held_request.calm;
                    gap_left <= idle_length(held_request.calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result is matched field by field against the oldest
    // expectation. The output stall is raised at random, except in calm stretches.
    always @(posedge i_clk) begin : result_monitor
        t_bus_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual kind %0d data 0x%0h offset %0d",
                             $time, o_kind, o_read_data, o_line_offset);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("plane_bit0", want.plane0, o_plane_bit0);
                    check_field("plane_bit1", want.plane1, o_plane_bit1);
                    check_field("plane_bit2", want.plane2, o_plane_bit2);
                    check_field("line_offset", want.line_offset, o_line_offset);
                    check_field("last", want.last, o_last);
                end
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    stall_left <= idle_length(calm_now);
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned pick, cell_no, idx, area;
        logic [15:0] addr, last_addr;
        logic [7:0]  last_data, value;
        logic        calm, drain;

        for (int i = 0; i < RAM_BYTES; i++)
            shadow_ram[i] = '0;
        last_addr = 16'h3000 + 16'(TEXT_COLUMNS);
        last_data = '0;

        // Glyphs are loaded first for the few character codes that ever reach the screen.
        // Some lines are solid or empty, and the index carries random high bits.
        for (int k = 0; k < SCREEN_CODES; k++) begin
            for (int i = 0; i < 8; i++) begin
                pick = $urandom_range(0, 7);
                value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                queue_request(FUNC_FONT_LOAD,
                              16'(int'(screen_code(k)) * 8 + i +
                                  FONT_BYTES * $urandom_range(0, 31)),
                              value, random_keys(), 1'b0, k >= SCREEN_CODES / 2);
            end
        end

        // Part of the monitor ROM, with both ends and the byte that a write tries to hit.
        queue_monitor_load(0, 1'b0);
        queue_monitor_load(MONITOR_ROM_BYTES - 1, 1'b0);
        queue_monitor_load('h10, 1'b0);
        repeat (5)
            queue_monitor_load($urandom_range(0, MONITOR_ROM_BYTES - 1), 1'b0);

        // Directed requests: the map edges, the screen corners, unchanged and ignored
        // writes, the key port and the unused function codes.
        queue_request(FUNC_MEM_READ, 16'h0000, 8'h00, '0, 1'b1, 1'b0);
        queue_request(FUNC_MEM_READ, 16'h1FFF, 8'hFF, '1, 1'b0, 1'b0);
        queue_request(FUNC_MEM_READ, 16'h2000, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_READ, 16'h3000, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_READ, 16'h7FFF, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_READ, 16'h8000, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_READ, 16'hFFFF, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_WRITE, 16'h3000, 8'h5A, '0, 1'b0, 1'b0);  // hidden row
        queue_request(FUNC_MEM_READ, 16'h3000, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_WRITE, 16'h3028, 8'hFF, '0, 1'b0, 1'b0);  // first visible cell
        queue_request(FUNC_MEM_WRITE, 16'h3428, 8'h8E, '0, 1'b0, 1'b0);  // its colour
        queue_request(FUNC_MEM_WRITE, 16'h3428, 8'h8E, '0, 1'b0, 1'b0);  // unchanged
        queue_request(FUNC_MEM_WRITE, 16'h33E7, 8'h80, '0, 1'b0, 1'b0);  // last visible cell
        queue_request(FUNC_MEM_WRITE, 16'h37E7, 8'h17, '0, 1'b0, 1'b0);  // background only
        queue_request(FUNC_MEM_WRITE, 16'h33E8, 8'h01, '0, 1'b0, 1'b0);  // past the last row
        queue_request(FUNC_MEM_WRITE, 16'h37FF, 8'h3C, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_WRITE, 16'h3800, 8'h77, '0, 1'b0, 1'b0);  // RAM beyond screen
        queue_request(FUNC_MEM_WRITE, 16'h7FFF, 8'hA5, '0, 1'b0, 1'b0);
        queue_request(FUNC_MEM_WRITE, 16'h2FFF, 8'h11, '0, 1'b0, 1'b0);  // gap below RAM
        queue_request(FUNC_MEM_WRITE, 16'h8000, 8'h22, '0, 1'b0, 1'b0);  // above RAM
        queue_request(FUNC_MEM_WRITE, 16'h0010, 8'h33, '0, 1'b0, 1'b0);  // into the ROM
        queue_request(FUNC_MEM_READ, 16'h0010, 8'h00, '0, 1'b0, 1'b0);
        queue_request(FUNC_PORT_READ, 16'h00FF, 8'h00, '1, 1'b0, 1'b0);  // every row
        queue_request(FUNC_PORT_READ, 16'hFFFF, 8'h00, '1, 1'b0, 1'b0);  // no row
        queue_request(FUNC_PORT_READ, 16'hFE12, 8'h00, '1, 1'b0, 1'b0);  // not the key port
        queue_request(FUNC_UNUSED_FIRST, 16'h3100, 8'h44, '0, 1'b0, 1'b0);
        queue_request(FUNC_UNUSED_LAST, 16'h0000, 8'hFF, '1, 1'b0, 1'b0);

        // Random requests, weighted towards screen writes so that most of them repaint.
        // A calm stretch runs without idling, and a few requests wait for the output
        // to drain completely before they are offered.
        for (int n = 0; n < 65; n++) begin
            calm = (n >= 25 && n < 40);
            drain = (n == 10 || n == 30 || n == 50);
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                if ($urandom_range(0, 9) == 0) begin
                    addr = last_addr;
                    value = last_data;
                end else begin
                    idx = $urandom_range(0, 99);
                    cell_no = (idx < 85) ? $urandom_range(TEXT_COLUMNS, CELL_LIMIT - 1) :
                              (idx < 93) ? $urandom_range(0, TEXT_COLUMNS - 1) :
                                           $urandom_range(CELL_LIMIT, 1023);
                    area = $urandom_range(0, 1);
                    addr = 16'(RAM_BASE + (area * COLOUR_AREA) + cell_no);
                    // A character code is always one whose glyph has been loaded.
                    value = (area == 0) ? screen_code($urandom_range(0, SCREEN_CODES - 1)) :
                                          8'($urandom);
                end
                last_addr = addr;
                last_data = value;
                queue_request(FUNC_MEM_WRITE, addr, value, random_keys(), drain, calm);
            end else if (pick < 50) begin
                addr = 16'($urandom_range(SCREEN_END, RAM_BASE + RAM_BYTES - 1));
                queue_request(FUNC_MEM_WRITE, addr, 8'($urandom), random_keys(), drain, calm);
            end else if (pick < 55) begin
                addr = $urandom_range(0, 1) ? 16'($urandom_range(0, RAM_BASE - 1)) :
                                              16'($urandom_range(RAM_BASE + RAM_BYTES, 'hFFFF));
                queue_request(FUNC_MEM_WRITE, addr, 8'($urandom), random_keys(), drain, calm);
            end else if (pick < 72) begin
                idx = $urandom_range(0, 3);
                if (idx == 0)
                    addr = 16'(rom_known_list[$urandom_range(0, rom_known_list.size() - 1)]);
                else if (idx == 1)
                    addr = 16'($urandom_range(RAM_BASE, SCREEN_END - 1));
                else if (idx == 2)
                    addr = 16'($urandom_range(SCREEN_END, RAM_BASE + RAM_BYTES - 1));
                else
                    addr = $urandom_range(0, 1) ? 16'($urandom_range(ROM_TOP, RAM_BASE - 1)) :
                                                  16'($urandom_range(RAM_BASE + RAM_BYTES, 'hFFFF));
                queue_request(FUNC_MEM_READ, addr, 8'($urandom), random_keys(), drain, calm);
            end else if (pick < 88) begin
                addr = 16'($urandom);
                if ($urandom_range(0, 3) != 0)
                    addr[7:0] = KEY_PORT;
                queue_request(FUNC_PORT_READ, addr, 8'($urandom), random_keys(), drain, calm);
            end else if (pick < 94) begin
                queue_monitor_load($urandom_range(0, MONITOR_ROM_BYTES - 1), calm);
            end else if (pick < 97) begin
                queue_request(FUNC_FONT_LOAD, 16'($urandom), 8'($urandom), random_keys(),
                              drain, calm);
            end else begin
                queue_request(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                              16'($urandom), 8'($urandom), random_keys(), drain, calm);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone in and every result has come out, then a
        // little longer so that a stray extra result would still be caught.
        while (request_q.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
